@@ hdl/mpr_pkg.sv @@
package mpr_pkg;

    typedef enum logic [2:0] {
        CMD_READ     = 3'd0,
        CMD_WRITE    = 3'd1,
        CMD_MOTION   = 3'd2,
        CMD_BTN_DOWN = 3'd3,
        CMD_BTN_UP   = 3'd4,
        CMD_TICK     = 3'd5
    } cmd_t;

    // Register offsets
    localparam logic [3:0] ADDR_POS_X_LO = 4'd0;
    localparam logic [3:0] ADDR_POS_X_HI = 4'd1;
    localparam logic [3:0] ADDR_POS_Y_LO = 4'd2;
    localparam logic [3:0] ADDR_POS_Y_HI = 4'd3;
    localparam logic [3:0] ADDR_BXL_LO   = 4'd4;
    localparam logic [3:0] ADDR_BXL_HI   = 4'd5;
    localparam logic [3:0] ADDR_BXH_LO   = 4'd6;
    localparam logic [3:0] ADDR_BXH_HI   = 4'd7;
    localparam logic [3:0] ADDR_BYL_LO   = 4'd8;
    localparam logic [3:0] ADDR_BYL_HI   = 4'd9;
    localparam logic [3:0] ADDR_BYH_LO   = 4'd10;
    localparam logic [3:0] ADDR_BYH_HI   = 4'd11;
    localparam logic [3:0] ADDR_STATUS   = 4'd14;
    localparam logic [3:0] ADDR_MODE     = 4'd15;

    localparam logic [7:0]  UNUSED_READ_VALUE = 8'hEE;
    localparam logic [15:0] BOUND_RESET       = 16'd1023;
    localparam logic [7:0]  INT_MASK          = 8'h0F;

    // Status bit positions
    localparam int ST_BUTTON      = 7;
    localparam int ST_LAST_BUTTON = 6;
    localparam int ST_MOVED       = 5;
    localparam int ST_INT_VBL     = 3;
    localparam int ST_INT_BUTTON  = 2;
    localparam int ST_INT_MOTION  = 1;
    localparam logic [7:0] ST_READ_CLEAR = 8'h2E;

    // Mode bit positions
    localparam int MD_INT_MOTION = 1;
    localparam int MD_INT_BUTTON = 2;

    typedef struct packed {
        logic [2:0]         command;
        logic [3:0]         reg_addr;
        logic [7:0]         write_data;
        logic signed [15:0] delta_x;
        logic signed [15:0] delta_y;
    } req_t;

    // Low bound first, then high bound: high wins when the bounds cross.
    function automatic logic [15:0] clamp_axis(input logic signed [16:0] v,
                                               input logic [15:0] lo,
                                               input logic [15:0] hi);
        logic signed [16:0] l;
        logic signed [16:0] h;
        logic signed [16:0] r;
        l = {lo[15], lo};
        h = {hi[15], hi};
        r = v;
        if (r < l) r = l;
        if (r > h) r = h;
        return r[15:0];
    endfunction

    function automatic logic [15:0] set_byte(input logic [15:0] word,
                                             input logic hi,
                                             input logic [7:0] b);
        return hi ? {b, word[7:0]} : {word[15:8], b};
    endfunction

    function automatic logic [7:0] get_byte(input logic [15:0] word, input logic hi);
        return hi ? word[15:8] : word[7:0];
    endfunction

endpackage

@@ hdl/mpr_core.sv @@
module mpr_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          exec,
    input  mpr_pkg::req_t req,
    output logic [7:0]    read_data_next,
    output logic          irq_next
);
    import mpr_pkg::*;

    logic [15:0] pos_x_reg, pos_y_reg, bxl_reg, bxh_reg, byl_reg, byh_reg;
    logic [15:0] pos_x_next, pos_y_next, bxl_next, bxh_next, byl_next, byh_next;
    logic [7:0]  status_reg, mode_reg, status_next, mode_next;
    logic        last_btn_reg, last_btn_next, irq_reg;
    logic [15:0] wr_px, wr_py;
    logic [7:0]  st_read;
    logic        addr_hi;
    cmd_t        cmd;

    assign addr_hi = req.reg_addr[0];
    assign cmd     = cmd_t'(req.command);

    always_comb
    begin
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        bxl_next       = bxl_reg;
        bxh_next       = bxh_reg;
        byl_next       = byl_reg;
        byh_next       = byh_reg;
        status_next    = status_reg;
        mode_next      = mode_reg;
        last_btn_next  = last_btn_reg;
        irq_next       = irq_reg;
        read_data_next = '0;
        wr_px          = pos_x_reg;
        wr_py          = pos_y_reg;
        st_read        = status_reg;
        st_read[ST_LAST_BUTTON] = last_btn_reg;

        unique case (cmd)
            CMD_READ:
            begin
                unique case (req.reg_addr) inside
                    ADDR_POS_X_LO, ADDR_POS_X_HI: read_data_next = get_byte(pos_x_reg, addr_hi);
                    ADDR_POS_Y_LO, ADDR_POS_Y_HI: read_data_next = get_byte(pos_y_reg, addr_hi);
                    ADDR_BXL_LO, ADDR_BXL_HI:     read_data_next = get_byte(bxl_reg, addr_hi);
                    ADDR_BXH_LO, ADDR_BXH_HI:     read_data_next = get_byte(bxh_reg, addr_hi);
                    ADDR_BYL_LO, ADDR_BYL_HI:     read_data_next = get_byte(byl_reg, addr_hi);
                    ADDR_BYH_LO, ADDR_BYH_HI:     read_data_next = get_byte(byh_reg, addr_hi);
                    ADDR_STATUS:
                    begin
                        // Latch button history, return, then drop event flags
                        read_data_next = st_read;
                        last_btn_next  = status_reg[ST_BUTTON];
                        status_next    = st_read & ~ST_READ_CLEAR;
                        irq_next       = |(mode_reg & INT_MASK & (st_read & ~ST_READ_CLEAR));
                    end
                    ADDR_MODE:                    read_data_next = mode_reg;
                    default:                      read_data_next = UNUSED_READ_VALUE;
                endcase
            end
            CMD_WRITE:
            begin
                unique case (req.reg_addr) inside
                    ADDR_POS_X_LO, ADDR_POS_X_HI: wr_px = set_byte(pos_x_reg, addr_hi, req.write_data);
                    ADDR_POS_Y_LO, ADDR_POS_Y_HI: wr_py = set_byte(pos_y_reg, addr_hi, req.write_data);
                    ADDR_BXL_LO, ADDR_BXL_HI:     bxl_next = set_byte(bxl_reg, addr_hi, req.write_data);
                    ADDR_BXH_LO, ADDR_BXH_HI:     bxh_next = set_byte(bxh_reg, addr_hi, req.write_data);
                    ADDR_BYL_LO, ADDR_BYL_HI:     byl_next = set_byte(byl_reg, addr_hi, req.write_data);
                    ADDR_BYH_LO, ADDR_BYH_HI:     byh_next = set_byte(byh_reg, addr_hi, req.write_data);
                    ADDR_STATUS:                  status_next = req.write_data;
                    ADDR_MODE:                    mode_next = req.write_data;
                    default:                      ;
                endcase
                // Every write re-clamps against the updated bounds
                pos_x_next = clamp_axis({wr_px[15], wr_px}, bxl_next, bxh_next);
                pos_y_next = clamp_axis({wr_py[15], wr_py}, byl_next, byh_next);
            end
            CMD_MOTION:
            begin
                if ((req.delta_x != '0) || (req.delta_y != '0))
                begin
                    pos_x_next = clamp_axis({pos_x_reg[15], pos_x_reg} +
                                            {req.delta_x[15], req.delta_x}, bxl_reg, bxh_reg);
                    pos_y_next = clamp_axis({pos_y_reg[15], pos_y_reg} +
                                            {req.delta_y[15], req.delta_y}, byl_reg, byh_reg);
                    status_next[ST_MOVED] = 1'b1;
                    if (mode_reg[MD_INT_MOTION])
                    begin
                        status_next[ST_INT_MOTION] = 1'b1;
                        irq_next = |(mode_reg & INT_MASK & status_next);
                    end
                end
            end
            CMD_BTN_DOWN:
            begin
                status_next[ST_BUTTON] = 1'b1;
                if (mode_reg[MD_INT_BUTTON])
                begin
                    status_next[ST_INT_BUTTON] = 1'b1;
                    irq_next = |(mode_reg & INT_MASK & status_next);
                end
            end
            CMD_BTN_UP:
            begin
                status_next[ST_BUTTON] = 1'b0;
            end
            CMD_TICK:
            begin
                status_next[ST_INT_VBL] = 1'b1;
                irq_next = |(mode_reg & INT_MASK & status_next);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            bxl_reg      <= '0;
            bxh_reg      <= BOUND_RESET;
            byl_reg      <= '0;
            byh_reg      <= BOUND_RESET;
            status_reg   <= '0;
            mode_reg     <= '0;
            last_btn_reg <= 1'b0;
            irq_reg      <= 1'b0;
        end
        else if (exec)
        begin
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
            bxl_reg      <= bxl_next;
            bxh_reg      <= bxh_next;
            byl_reg      <= byl_next;
            byh_reg      <= byh_next;
            status_reg   <= status_next;
            mode_reg     <= mode_next;
            last_btn_reg <= last_btn_next;
            irq_reg      <= irq_next;
        end
    end

endmodule

@@ hdl/mouse_position_register_block.sv @@
// Mouse position register block: byte registers of a bus mouse card plus
// event inputs (motion, button press/release, frame tick).
//
// Input channel: in_valid/in_ready carry one request (command, reg_addr,
// write_data, delta_x, delta_y). Output channel: out_valid/out_ready carry
// one response per request (read_data, irq).
//
// A request lands in the input register, then the single-pass execute logic
// (one 17-bit add and two compares per axis) updates the register file and
// loads the response register when the response slot is free or draining.
// Throughput: one request per cycle while out_ready is high; the input
// register and the response register are the only stages, so a new request
// is taken while an earlier response still waits.
// Stall: while out_ready is low the response holds, the pending request
// waits in the input register, and in_ready drops once both are full.
// Reset: rst_n clears both stages, positions, status, mode and irq, and
// loads both high bounds with 1023.
module mouse_position_register_block (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         command,
    input  logic [3:0]         reg_addr,
    input  logic [7:0]         write_data,
    input  logic signed [15:0] delta_x,
    input  logic signed [15:0] delta_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         read_data,
    output logic               irq
);
    import mpr_pkg::*;

    logic       in_vld_reg, in_vld_next;
    req_t       in_req_reg;
    logic       out_vld_reg, out_vld_next;
    logic [7:0] rd_reg;
    logic       irq_reg;
    logic       advance;
    logic       take;
    logic [7:0] rd_next;
    logic       irq_next;

    // Execute the held request when the response slot is free or draining
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;
    assign take     = in_valid && in_ready;

    assign in_vld_next  = take || (in_vld_reg && !advance);
    assign out_vld_next = advance || (out_vld_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Capture the request payload on acceptance
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_req_reg.command    <= command;
            in_req_reg.reg_addr   <= reg_addr;
            in_req_reg.write_data <= write_data;
            in_req_reg.delta_x    <= delta_x;
            in_req_reg.delta_y    <= delta_y;
        end
    end

    mpr_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .exec           (advance),
        .req            (in_req_reg),
        .read_data_next (rd_next),
        .irq_next       (irq_next)
    );

    // Hold the response until the receiver takes it
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rd_reg  <= rd_next;
            irq_reg <= irq_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign read_data = rd_reg;
    assign irq       = irq_reg;

endmodule

@@ hdl/mpr_checker.sv @@
module mpr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [2:0]  command,
    input logic [3:0]  reg_addr,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  read_data,
    input logic        irq
);

    // Response slot is empty while reset is held
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("response valid during reset");

    // A stalled response keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(irq))
        else $error("stalled response changed");

    // An accepted request whose output is then ready yields a valid response
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready |=> out_valid)
        else $error("response missing after request");

    // Requester holds a stalled request
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(command) && $stable(reg_addr))
        else $error("stalled request changed");

endmodule

bind mouse_position_register_block mpr_checker u_mpr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .reg_addr  (reg_addr),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data),
    .irq       (irq)
);

@@ verif/tb_top.sv @@
module tb_top;
    import mpr_pkg::*;

    // Commands outside the defined set, and the two offsets with no register
    // behind them.
    localparam logic [2:0] CMD_SPARE_6  = 3'd6;
    localparam logic [2:0] CMD_SPARE_7  = 3'd7;
    localparam logic [3:0] ADDR_SPARE_C = 4'd12;
    localparam logic [3:0] ADDR_SPARE_D = 4'd13;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_LEN     = 300;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [7:0] rd;
        logic       irq;
    } reply_t;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic [2:0]         command    = '0;
    logic [3:0]         reg_addr   = '0;
    logic [7:0]         write_data = '0;
    logic signed [15:0] delta_x    = '0;
    logic signed [15:0] delta_y    = '0;
    logic               out_valid;
    logic               out_ready  = 1'b0;
    logic [7:0]         read_data;
    logic               irq;

    // Shadow copy of the card's registers, advanced once per accepted request.
    logic [15:0] card_px, card_py;
    logic [15:0] card_xlo, card_xhi, card_ylo, card_yhi;
    logic [7:0]  card_status, card_mode;
    logic        card_last_btn;
    logic        card_irq;

    reply_t reply_due[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int tx_idle_pct    = 0;
    int rx_idle_pct    = 0;
    int hold_orders    = 0;
    int hold_taken     = 0;
    int hold_left      = 0;
    int stall_left     = 0;

    mouse_position_register_block u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .reg_addr   (reg_addr),
        .write_data (write_data),
        .delta_x    (delta_x),
        .delta_y    (delta_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data),
        .irq        (irq)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the handshake locks up.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Clamp low bound first, then high, so the high bound wins when the
    // two have crossed.
    function automatic logic [15:0] fit_axis(input int v, input logic [15:0] lo,
                                             input logic [15:0] hi);
        int l;
        int h;
        l = $signed(lo);
        h = $signed(hi);
        if (v < l) v = l;
        if (v > h) v = h;
        return v[15:0];
    endfunction

    function automatic logic [15:0] with_byte(input logic [15:0] w, input logic upper,
                                              input logic [7:0] b);
        if (upper) w[15:8] = b;
        else       w[7:0]  = b;
        return w;
    endfunction

    function automatic logic [7:0] pick_byte(input logic [15:0] w, input logic upper);
        return upper ? w[15:8] : w[7:0];
    endfunction

    function automatic void refresh_card_irq();
        card_irq = |(card_mode & INT_MASK & card_status);
    endfunction

    // Apply one request to the shadow registers and return the response the
    // card should give for it.
    function automatic reply_t advance_card(input req_t r);
        reply_t rep;
        int     nx;
        int     ny;
        rep.rd = 8'h00;
        case (r.command)
            CMD_READ:
            begin
                case (r.reg_addr)
                    ADDR_POS_X_LO, ADDR_POS_X_HI: rep.rd = pick_byte(card_px, r.reg_addr[0]);
                    ADDR_POS_Y_LO, ADDR_POS_Y_HI: rep.rd = pick_byte(card_py, r.reg_addr[0]);
                    ADDR_BXL_LO, ADDR_BXL_HI:     rep.rd = pick_byte(card_xlo, r.reg_addr[0]);
                    ADDR_BXH_LO, ADDR_BXH_HI:     rep.rd = pick_byte(card_xhi, r.reg_addr[0]);
                    ADDR_BYL_LO, ADDR_BYL_HI:     rep.rd = pick_byte(card_ylo, r.reg_addr[0]);
                    ADDR_BYH_LO, ADDR_BYH_HI:     rep.rd = pick_byte(card_yhi, r.reg_addr[0]);
                    ADDR_STATUS:
                    begin
                        // Rotate the button history, return, then clear events.
                        card_status[ST_LAST_BUTTON] = card_last_btn;
                        card_last_btn = card_status[ST_BUTTON];
                        rep.rd = card_status;
                        card_status = card_status & ~ST_READ_CLEAR;
                        refresh_card_irq();
                    end
                    ADDR_MODE: rep.rd = card_mode;
                    default:   rep.rd = UNUSED_READ_VALUE;
                endcase
            end
            CMD_WRITE:
            begin
                case (r.reg_addr)
                    ADDR_POS_X_LO, ADDR_POS_X_HI:
                        card_px = with_byte(card_px, r.reg_addr[0], r.write_data);
                    ADDR_POS_Y_LO, ADDR_POS_Y_HI:
                        card_py = with_byte(card_py, r.reg_addr[0], r.write_data);
                    ADDR_BXL_LO, ADDR_BXL_HI:
                        card_xlo = with_byte(card_xlo, r.reg_addr[0], r.write_data);
                    ADDR_BXH_LO, ADDR_BXH_HI:
                        card_xhi = with_byte(card_xhi, r.reg_addr[0], r.write_data);
                    ADDR_BYL_LO, ADDR_BYL_HI:
                        card_ylo = with_byte(card_ylo, r.reg_addr[0], r.write_data);
                    ADDR_BYH_LO, ADDR_BYH_HI:
                        card_yhi = with_byte(card_yhi, r.reg_addr[0], r.write_data);
                    ADDR_STATUS: card_status = r.write_data;
                    ADDR_MODE:   card_mode = r.write_data;
                    default: ;
                endcase
                // Any write, even to a spare offset, re-clamps both axes.
                card_px = fit_axis($signed(card_px), card_xlo, card_xhi);
                card_py = fit_axis($signed(card_py), card_ylo, card_yhi);
            end
            CMD_MOTION:
            begin
                if (r.delta_x != 0 || r.delta_y != 0)
                begin
                    nx = $signed(card_px) + $signed(r.delta_x);
                    ny = $signed(card_py) + $signed(r.delta_y);
                    card_px = fit_axis(nx, card_xlo, card_xhi);
                    card_py = fit_axis(ny, card_ylo, card_yhi);
                    card_status[ST_MOVED] = 1'b1;
                    if (card_mode[MD_INT_MOTION])
                    begin
                        card_status[ST_INT_MOTION] = 1'b1;
                        refresh_card_irq();
                    end
                end
            end
            CMD_BTN_DOWN:
            begin
                card_status[ST_BUTTON] = 1'b1;
                if (card_mode[MD_INT_BUTTON])
                begin
                    card_status[ST_INT_BUTTON] = 1'b1;
                    refresh_card_irq();
                end
            end
            CMD_BTN_UP: card_status[ST_BUTTON] = 1'b0;
            CMD_TICK:
            begin
                card_status[ST_INT_VBL] = 1'b1;
                refresh_card_irq();
            end
            default: ;
        endcase
        rep.irq = card_irq;
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap(input int pct);
        if ($urandom_range(99) >= pct) return 0;
        if ($urandom_range(9) == 0) return $urandom_range(40, 12);
        return $urandom_range(3, 1);
    endfunction

    function automatic req_t make_req(input logic [2:0] c, input logic [3:0] a,
                                      input logic [7:0] d, input int dx, input int dy);
        req_t r;
        r.command    = c;
        r.reg_addr   = a;
        r.write_data = d;
        r.delta_x    = dx[15:0];
        r.delta_y    = dy[15:0];
        return r;
    endfunction

    // Called at a falling edge. Hold valid and payload until the request is
    // taken, then leave valid high so the next request can follow directly.
    task automatic send_request(input req_t r);
        int gap;
        gap = pick_gap(tx_idle_pct);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   = 1'b1;
        command    = r.command;
        reg_addr   = r.reg_addr;
        write_data = r.write_data;
        delta_x    = r.delta_x;
        delta_y    = r.delta_y;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        reply_due.push_back(advance_card(r));
        @(negedge clk);
    endtask

    // Drop valid and wait until every outstanding response is back.
    task automatic wait_for_replies();
        in_valid = 1'b0;
        while (reply_due.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h7F;
            3:       return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    // Small steps keep the pointer wandering inside the window; the full
    // range and the two extremes drive it into the bounds.
    function automatic int rand_delta();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 32767;
            2:       return -32768;
            3, 4:    return $signed(16'($urandom));
            default: return int'($urandom_range(128)) - 64;
        endcase
    endfunction

    function automatic req_t random_req();
        req_t r;
        int   sel;
        sel = $urandom_range(99);
        // Unused fields still carry random bits.
        r = make_req(CMD_READ, 4'($urandom), 8'($urandom),
                     $signed(16'($urandom)), $signed(16'($urandom)));
        if (sel < 22)
        begin
            if ($urandom_range(3) == 0) r.reg_addr = ADDR_STATUS;
        end
        else if (sel < 44)
        begin
            r.command    = CMD_WRITE;
            r.write_data = rand_byte();
        end
        else if (sel < 70)
        begin
            r.command = CMD_MOTION;
            if ($urandom_range(11) == 0)
            begin
                r.delta_x = '0;
                r.delta_y = '0;
            end
            else
            begin
                r.delta_x = 16'(rand_delta());
                r.delta_y = 16'(rand_delta());
            end
        end
        else if (sel < 78) r.command = CMD_BTN_DOWN;
        else if (sel < 86) r.command = CMD_BTN_UP;
        else if (sel < 96) r.command = CMD_TICK;
        else r.command = $urandom_range(1) ? CMD_SPARE_6 : CMD_SPARE_7;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------

    // Stall the response channel at random; a hold order from a test
    // forces a long stretch with ready low, counted here.
    always @(negedge clk)
    begin
        if (hold_orders != hold_taken)
        begin
            hold_taken = hold_orders;
            hold_left  = HOLD_LEN;
        end
        if (hold_left > 0)
        begin
            out_ready = 1'b0;
            hold_left--;
        end
        else if (stall_left > 0)
        begin
            out_ready = 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready  = 1'b1;
            stall_left = pick_gap(rx_idle_pct);
        end
    end

    task automatic flag_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch %s: expected %0h got %0h", what, want, got);
    endtask

    // Compare each accepted response against the oldest prediction.
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (reply_due.size() == 0)
                flag_mismatch("response with no request outstanding", 0, read_data);
            else
            begin
                want = reply_due.pop_front();
                if (read_data !== want.rd) flag_mismatch("read_data", want.rd, read_data);
                if (irq !== want.irq) flag_mismatch("irq", want.irq, irq);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Corners: reset values, both spare offsets, clamping at both field
    // extremes, zero motion, every event and interrupt source, the button
    // history, crossed bounds, writes that do not refresh the interrupt,
    // negative positions and both undefined commands.
    task automatic test_directed_corners();
        tx_idle_pct = 30;
        rx_idle_pct = 30;
        send_request(make_req(CMD_READ, ADDR_BXH_HI, 8'h00, 0, 0));
        send_request(make_req(CMD_READ, ADDR_SPARE_C, 8'hFF, 0, 0));
        send_request(make_req(CMD_WRITE, ADDR_MODE, 8'h0E, 0, 0));
        send_request(make_req(CMD_MOTION, 4'h0, 8'h00, 32767, -32768));
        send_request(make_req(CMD_MOTION, 4'h0, 8'h00, 0, 0));
        send_request(make_req(CMD_BTN_DOWN, 4'h0, 8'h00, 0, 0));
        send_request(make_req(CMD_READ, ADDR_STATUS, 8'h00, 0, 0));
        send_request(make_req(CMD_BTN_UP, 4'h0, 8'h00, 0, 0));
        send_request(make_req(CMD_READ, ADDR_STATUS, 8'h00, 0, 0));
        send_request(make_req(CMD_TICK, 4'h0, 8'h00, 0, 0));
        send_request(make_req(CMD_READ, ADDR_STATUS, 8'h00, 0, 0));
        // Push the low X bound above the high one: high must win.
        send_request(make_req(CMD_WRITE, ADDR_BXL_LO, 8'hFF, 0, 0));
        send_request(make_req(CMD_WRITE, ADDR_BXL_HI, 8'h7F, 0, 0));
        send_request(make_req(CMD_MOTION, 4'h0, 8'h00, -32768, 32767));
        send_request(make_req(CMD_READ, ADDR_POS_X_LO, 8'h00, 0, 0));
        send_request(make_req(CMD_READ, ADDR_POS_X_HI, 8'h00, 0, 0));
        send_request(make_req(CMD_WRITE, ADDR_SPARE_D, 8'hAB, 0, 0));
        send_request(make_req(CMD_WRITE, ADDR_STATUS, 8'hFF, 0, 0));
        send_request(make_req(CMD_READ, ADDR_MODE, 8'h00, 0, 0));
        send_request(make_req(CMD_WRITE, ADDR_POS_X_HI, 8'h80, 0, 0));
        send_request(make_req(CMD_WRITE, ADDR_BYL_HI, 8'h80, 0, 0));
        send_request(make_req(CMD_SPARE_6, 4'hF, 8'hFF, -1, -1));
        send_request(make_req(CMD_SPARE_7, 4'hF, 8'hFF, -1, -1));
        send_request(make_req(CMD_READ, ADDR_STATUS, 8'h00, 0, 0));
    endtask

    task automatic test_random_mix(input int count);
        tx_idle_pct = 35;
        rx_idle_pct = 35;
        repeat (count) send_request(random_req());
    endtask

    // Hold the response side off while requests keep coming, so both
    // stages fill and in_ready drops.
    task automatic test_output_hold();
        tx_idle_pct = 0;
        rx_idle_pct = 20;
        hold_orders++;
        repeat (40) send_request(random_req());
    endtask

    // Pause the request side until everything has drained, then resume.
    task automatic test_sender_pause();
        tx_idle_pct = 25;
        rx_idle_pct = 25;
        repeat (30) send_request(random_req());
        wait_for_replies();
        repeat (30) send_request(random_req());
    endtask

    // Full rate on both sides.
    task automatic test_back_to_back();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (150) send_request(random_req());
    endtask

    initial
    begin
        card_px       = '0;
        card_py       = '0;
        card_xlo      = '0;
        card_xhi      = BOUND_RESET;
        card_ylo      = '0;
        card_yhi      = BOUND_RESET;
        card_status   = '0;
        card_mode     = '0;
        card_last_btn = 1'b0;
        card_irq      = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_corners();
        test_random_mix(300);
        test_output_hold();
        test_sender_pause();
        test_back_to_back();
        test_random_mix(200);
        test_output_hold();
        test_random_mix(180);

        wait_for_replies();
        // Watch a little longer for stray responses.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
